// File: rtl/core/spht_pkg.sv
// shared constants, codes and types of the shape pixel hit test
package spht_pkg;

    localparam int COORD_W    = 10;
    localparam int COLOR_W    = 24;
    localparam int KIND_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int CLIP_W     = 13;
    localparam int SQ_W       = 2 * COORD_W;

    localparam int DEF_WIDTH  = 1024;
    localparam int DEF_HEIGHT = 1024;

    // primitive kinds
    localparam logic [KIND_W-1:0] KIND_RECT_OUTLINE  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_RECT_FILLED   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_RING          = 3'd2;
    localparam logic [KIND_W-1:0] KIND_HOVER_OUTLINE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_HOVER_RING    = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PRIM_KIND   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_X    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_Y    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EXTENT_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EXTENT_Y    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_THICKNESS   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_COLOR  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_HOVER_COLOR = 3'd7;

    typedef struct packed {
        logic [KIND_W-1:0]  prim_kind;
        logic [COORD_W-1:0] anchor_x;
        logic [COORD_W-1:0] anchor_y;
        logic [COORD_W-1:0] extent_x;
        logic [COORD_W-1:0] extent_y;
        logic [COORD_W-1:0] thickness;
        logic [COLOR_W-1:0] base_color;
        logic [COLOR_W-1:0] hover_color;
    } t_cfg;

endpackage

// File: rtl/core/spht_cfg.sv
// configuration register file of the shape pixel hit test
module spht_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [spht_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [spht_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output spht_pkg::t_cfg                     o_cfg
);
    import spht_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PRIM_KIND:   r_cfg.prim_kind   <= i_cfg_data[KIND_W-1:0];
                REG_ANCHOR_X:    r_cfg.anchor_x    <= i_cfg_data[COORD_W-1:0];
                REG_ANCHOR_Y:    r_cfg.anchor_y    <= i_cfg_data[COORD_W-1:0];
                REG_EXTENT_X:    r_cfg.extent_x    <= i_cfg_data[COORD_W-1:0];
                REG_EXTENT_Y:    r_cfg.extent_y    <= i_cfg_data[COORD_W-1:0];
                REG_THICKNESS:   r_cfg.thickness   <= i_cfg_data[COORD_W-1:0];
                REG_BASE_COLOR:  r_cfg.base_color  <= i_cfg_data[COLOR_W-1:0];
                REG_HOVER_COLOR: r_cfg.hover_color <= i_cfg_data[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/core/spht_cover.sv
// coverage and color logic between the input and result registers
module spht_cover #(
    parameter int WIDTH  = spht_pkg::DEF_WIDTH,
    parameter int HEIGHT = spht_pkg::DEF_HEIGHT
) (
    input  spht_pkg::t_cfg                     i_cfg,
    input  logic [spht_pkg::COORD_W-1:0]       i_px,
    input  logic [spht_pkg::COORD_W-1:0]       i_py,
    input  logic [spht_pkg::COORD_W-1:0]       i_cx,
    input  logic [spht_pkg::COORD_W-1:0]       i_cy,
    output logic                               o_paint,
    output logic [spht_pkg::COLOR_W-1:0]       o_color
);
    import spht_pkg::*;

    localparam logic [CLIP_W-1:0] CLIP_X = CLIP_W'(WIDTH);
    localparam logic [CLIP_W-1:0] CLIP_Y = CLIP_W'(HEIGHT);

    function automatic logic [COORD_W-1:0] abs_diff(
        input logic [COORD_W-1:0] a,
        input logic [COORD_W-1:0] b
    );
        abs_diff = (a >= b) ? (a - b) : (b - a);
    endfunction

    logic               pix_box;
    logic               cur_box;
    logic               edge_hit;
    logic [COORD_W-1:0] dpx, dpy, dcx, dcy, inner_mag;
    logic [SQ_W-1:0]    sq_px, sq_py, sq_cx, sq_cy, sq_r, sq_inner;
    logic [SQ_W:0]      d2_pix, d2_cur;
    logic               ring_hit;
    logic               ring_hover;
    logic               clipped;
    logic               hit;
    logic               hover;

    assign pix_box = (i_px >= i_cfg.anchor_x) && (i_px <= i_cfg.extent_x) &&
                     (i_py >= i_cfg.anchor_y) && (i_py <= i_cfg.extent_y);
    assign cur_box = (i_cx >= i_cfg.anchor_x) && (i_cx <= i_cfg.extent_x) &&
                     (i_cy >= i_cfg.anchor_y) && (i_cy <= i_cfg.extent_y);

    // near-edge bands, with ex - t moved across so nothing goes negative
    assign edge_hit =
        ({1'b0, i_px} <= ({1'b0, i_cfg.anchor_x} + {1'b0, i_cfg.thickness})) ||
        (({1'b0, i_px} + {1'b0, i_cfg.thickness}) >= {1'b0, i_cfg.extent_x}) ||
        ({1'b0, i_py} <= ({1'b0, i_cfg.anchor_y} + {1'b0, i_cfg.thickness})) ||
        (({1'b0, i_py} + {1'b0, i_cfg.thickness}) >= {1'b0, i_cfg.extent_y});

    // squares are taken on magnitudes, so the inner radius may go negative
    assign dpx       = abs_diff(i_px, i_cfg.anchor_x);
    assign dpy       = abs_diff(i_py, i_cfg.anchor_y);
    assign dcx       = abs_diff(i_cx, i_cfg.anchor_x);
    assign dcy       = abs_diff(i_cy, i_cfg.anchor_y);
    assign inner_mag = abs_diff(i_cfg.extent_x, i_cfg.thickness);

    assign sq_px    = dpx * dpx;
    assign sq_py    = dpy * dpy;
    assign sq_cx    = dcx * dcx;
    assign sq_cy    = dcy * dcy;
    assign sq_r     = i_cfg.extent_x * i_cfg.extent_x;
    assign sq_inner = inner_mag * inner_mag;

    assign d2_pix = {1'b0, sq_px} + {1'b0, sq_py};
    assign d2_cur = {1'b0, sq_cx} + {1'b0, sq_cy};

    assign ring_hit   = (d2_pix < {1'b0, sq_r}) && (d2_pix >= {1'b0, sq_inner});
    assign ring_hover = d2_cur < {1'b0, sq_r};

    assign clipped = ({{(CLIP_W-COORD_W){1'b0}}, i_px} >= CLIP_X) ||
                     ({{(CLIP_W-COORD_W){1'b0}}, i_py} >= CLIP_Y);

    always_comb begin
        hit   = 1'b0;
        hover = 1'b0;
        unique case (i_cfg.prim_kind)
            KIND_RECT_OUTLINE:  hit = pix_box && edge_hit;
            KIND_RECT_FILLED:   hit = pix_box;
            KIND_RING:          hit = ring_hit;
            KIND_HOVER_OUTLINE: begin
                hit   = pix_box && edge_hit;
                hover = cur_box;
            end
            KIND_HOVER_RING: begin
                hit   = ring_hit;
                hover = ring_hover;
            end
            default: begin
                hit   = 1'b0;
                hover = 1'b0;
            end
        endcase
    end

    assign o_paint = hit && !clipped;
    assign o_color = !o_paint ? '0 :
                     (hover ? i_cfg.hover_color : i_cfg.base_color);

endmodule

// File: rtl/core/shape_pixel_hit_test.sv
// top level of the shape pixel hit test: input register, coverage logic, result register
//
//  channel  direction  ports            contents (lowest bit first)
//  s        in         i_s_t*/o_s_tready tdata: pixel_x, pixel_y, cursor_x, cursor_y
//  m        out        o_m_t*/i_m_tready tdata: pixel_color; tuser: paint
//  cfg      in         i_cfg_*          idx selects register, data low bits taken
//
//  one transaction per cycle sustained while the output is not stalled; an input transaction
//  waits in the input register until the output is free, then the result register loads from the coverage logic
//  synchronous active-low reset empties both registers; config resets to zero
//  a stalled result holds; the input register still takes one more transaction,
//  after which o_s_tready drops until the result is taken
module shape_pixel_hit_test #(
    parameter int WIDTH  = spht_pkg::DEF_WIDTH,
    parameter int HEIGHT = spht_pkg::DEF_HEIGHT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // pixel_x, pixel_y, cursor_x, cursor_y
    input  logic [4*spht_pkg::COORD_W-1:0]     i_s_tdata,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // pixel_color
    output logic [spht_pkg::COLOR_W-1:0]       o_m_tdata,
    // paint
    output logic                               o_m_tuser,
    input  logic                               i_cfg_we,
    input  logic [spht_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [spht_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import spht_pkg::*;

    t_cfg               cfg;
    logic               r_in_valid;
    logic [COORD_W-1:0] r_px, r_py, r_cx, r_cy;
    logic               r_out_valid;
    logic               r_paint;
    logic [COLOR_W-1:0] r_color;
    logic               n_paint;
    logic [COLOR_W-1:0] n_color;
    logic               out_free;
    logic               advance;
    logic               s_take;

    spht_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    spht_cover #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT)
    ) u_cover (
        .i_cfg   (cfg),
        .i_px    (r_px),
        .i_py    (r_py),
        .i_cx    (r_cx),
        .i_cy    (r_cy),
        .o_paint (n_paint),
        .o_color (n_color)
    );

    assign out_free   = !r_out_valid || i_m_tready;
    assign advance    = r_in_valid && out_free;
    assign o_s_tready = !r_in_valid || out_free;
    assign s_take     = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_take) begin
            r_px <= i_s_tdata[COORD_W-1:0];
            r_py <= i_s_tdata[2*COORD_W-1:COORD_W];
            r_cx <= i_s_tdata[3*COORD_W-1:2*COORD_W];
            r_cy <= i_s_tdata[4*COORD_W-1:3*COORD_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_paint <= n_paint;
            r_color <= n_color;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_color;
    assign o_m_tuser  = r_paint;

    // an unpainted result always carries black
    a_unpainted_black : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata == '0))
        else $error("unpainted result with nonzero color");

    // a painted result carries one of the two configured colors
    a_painted_color : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |->
            ((o_m_tdata == cfg.base_color) || (o_m_tdata == cfg.hover_color)))
        else $error("painted result with an unconfigured color");

    // a held input item reaches the result register once the output frees up
    a_item_moves : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && out_free) |=> o_m_tvalid)
        else $error("input item lost on its way to the result register");

    // reset empties both stages
    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_m_tvalid && !r_in_valid))
        else $error("pipeline not empty after reset");

endmodule

// File: sim/tb_shape_pixel_hit_test.sv
// self-checking testbench for shape_pixel_hit_test: random and directed pixels scored in-bench
module tb_shape_pixel_hit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import spht_pkg::*;

    localparam int IDLE_LIMIT   = 4000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam logic [KIND_W-1:0] KIND_UNUSED_TOP = 3'd7;

    typedef struct packed {
        logic               paint;
        logic [COLOR_W-1:0] color;
    } t_hit;

    logic                    i_clk      = 1'b0;
    logic                    i_rst_n    = 1'b0;
    logic                    i_s_tvalid = 1'b0;
    logic                    o_s_tready;
    // pixel_x, pixel_y, cursor_x, cursor_y
    logic [4*COORD_W-1:0]    i_s_tdata  = '0;
    logic                    o_m_tvalid;
    logic                    i_m_tready = 1'b0;
    // pixel_color
    logic [COLOR_W-1:0]      o_m_tdata;
    // paint
    logic                    o_m_tuser;
    logic                    i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;

    t_cfg shape_cfg = '0;
    t_hit expected_hits[$];
    int   error_count    = 0;
    int   idle_cycles    = 0;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   hold_req       = 0;
    int   hold_left      = 0;

    shape_pixel_hit_test DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------- coverage predictor ----------------

    function automatic bit covers_box(longint x, longint y);
        return x >= longint'(shape_cfg.anchor_x) && x <= longint'(shape_cfg.extent_x) &&
               y >= longint'(shape_cfg.anchor_y) && y <= longint'(shape_cfg.extent_y);
    endfunction

    function automatic bit covers_outline(longint x, longint y);
        longint t;
        t = longint'(shape_cfg.thickness);
        if (!covers_box(x, y))
            return 1'b0;
        return x <= longint'(shape_cfg.anchor_x) + t || x >= longint'(shape_cfg.extent_x) - t ||
               y <= longint'(shape_cfg.anchor_y) + t || y >= longint'(shape_cfg.extent_y) - t;
    endfunction

    function automatic longint center_dist2(longint x, longint y);
        longint dx;
        longint dy;
        dx = x - longint'(shape_cfg.anchor_x);
        dy = y - longint'(shape_cfg.anchor_y);
        return dx * dx + dy * dy;
    endfunction

    function automatic bit covers_ring(longint x, longint y);
        longint r;
        longint inner;
        longint d;
        r     = longint'(shape_cfg.extent_x);
        inner = r - longint'(shape_cfg.thickness);
        d     = center_dist2(x, y);
        // a negative inner radius still squares to a positive bound
        return d < r * r && d >= inner * inner;
    endfunction

    function automatic t_hit predict_hit(logic [4*COORD_W-1:0] d);
        longint px;
        longint py;
        longint cx;
        longint cy;
        longint r;
        bit     hit;
        bit     hover;
        t_hit   h;
        px    = longint'(d[COORD_W-1:0]);
        py    = longint'(d[2*COORD_W-1:COORD_W]);
        cx    = longint'(d[3*COORD_W-1:2*COORD_W]);
        cy    = longint'(d[4*COORD_W-1:3*COORD_W]);
        r     = longint'(shape_cfg.extent_x);
        hit   = 1'b0;
        hover = 1'b0;
        case (shape_cfg.prim_kind)
            KIND_RECT_OUTLINE: hit = covers_outline(px, py);
            KIND_RECT_FILLED:  hit = covers_box(px, py);
            KIND_RING:         hit = covers_ring(px, py);
            KIND_HOVER_OUTLINE: begin
                hit   = covers_outline(px, py);
                hover = covers_box(cx, cy);
            end
            KIND_HOVER_RING: begin
                hit   = covers_ring(px, py);
                hover = center_dist2(cx, cy) < r * r;
            end
            default: ;
        endcase
        if (px >= DEF_WIDTH || py >= DEF_HEIGHT)
            hit = 1'b0;
        h.paint = hit;
        h.color = hit ? (hover ? shape_cfg.hover_color : shape_cfg.base_color) : '0;
        return h;
    endfunction

    // ---------------- monitors ----------------

    task automatic report_mismatch(string what, logic [COLOR_W-1:0] got,
                                   logic [COLOR_W-1:0] want);
        $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready)
            expected_hits.insert(expected_hits.size(), predict_hit(i_s_tdata));
    end

    always @(posedge i_clk) begin : check_result
        t_hit want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_hits.size() == 0) begin
                report_mismatch("result with no pixel pending", o_m_tdata, '0);
            end else begin
                want = expected_hits.pop_front();
                if (o_m_tuser !== want.paint)
                    report_mismatch("paint", COLOR_W'(o_m_tuser), COLOR_W'(want.paint));
                if (o_m_tdata !== want.color)
                    report_mismatch("pixel_color", o_m_tdata, want.color);
            end
        end
    end

    // receiver: random stalls, or a long hold-off counted here
    always @(posedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            i_m_tready <= 1'b0;
            hold_left--;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ---------------- drivers ----------------

    task automatic send_pixel(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
                              logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {cy, cx, py, px};
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic wait_results_done();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_hits.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            REG_PRIM_KIND:   shape_cfg.prim_kind   = data[KIND_W-1:0];
            REG_ANCHOR_X:    shape_cfg.anchor_x    = data[COORD_W-1:0];
            REG_ANCHOR_Y:    shape_cfg.anchor_y    = data[COORD_W-1:0];
            REG_EXTENT_X:    shape_cfg.extent_x    = data[COORD_W-1:0];
            REG_EXTENT_Y:    shape_cfg.extent_y    = data[COORD_W-1:0];
            REG_THICKNESS:   shape_cfg.thickness   = data[COORD_W-1:0];
            REG_BASE_COLOR:  shape_cfg.base_color  = data[COLOR_W-1:0];
            REG_HOVER_COLOR: shape_cfg.hover_color = data[COLOR_W-1:0];
            default: ;
        endcase
    endtask

    // writes the whole shape once the block has drained
    task automatic load_shape(logic [KIND_W-1:0] kind,
                              logic [COORD_W-1:0] ax, logic [COORD_W-1:0] ay,
                              logic [COORD_W-1:0] ex, logic [COORD_W-1:0] ey,
                              logic [COORD_W-1:0] t,
                              logic [COLOR_W-1:0] base, logic [COLOR_W-1:0] hover);
        wait_results_done();
        write_reg(REG_PRIM_KIND,   CFG_DATA_W'(kind));
        write_reg(REG_ANCHOR_X,    CFG_DATA_W'(ax));
        write_reg(REG_ANCHOR_Y,    CFG_DATA_W'(ay));
        write_reg(REG_EXTENT_X,    CFG_DATA_W'(ex));
        write_reg(REG_EXTENT_Y,    CFG_DATA_W'(ey));
        write_reg(REG_THICKNESS,   CFG_DATA_W'(t));
        write_reg(REG_BASE_COLOR,  CFG_DATA_W'(base));
        write_reg(REG_HOVER_COLOR, CFG_DATA_W'(hover));
        i_cfg_we <= 1'b0;
    endtask

    // coordinate near an edge or band boundary of [lo, hi], inside it, or anywhere, wrapped into the buffer
    function automatic logic [COORD_W-1:0] pick_coord(int lo, int hi, int t);
        int v;
        case ($urandom_range(5))
            0: v = lo + int'($urandom_range(2)) - 1;
            1: v = hi + int'($urandom_range(2)) - 1;
            2: v = lo + t + int'($urandom_range(2)) - 1;
            3: v = hi - t + int'($urandom_range(2)) - 1;
            4: v = (hi >= lo) ? lo + int'($urandom_range(hi - lo))
                              : hi + int'($urandom_range(lo - hi));
            default: v = int'($urandom_range(1023));
        endcase
        return v[COORD_W-1:0];
    endfunction

    task automatic rand_span(output int lo, output int hi);
        int w;
        lo = $urandom_range(1023);
        w  = ($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(120);
        hi = (lo + w > 1023) ? 1023 : lo + w;
        if ($urandom_range(9) == 0)
            {lo, hi} = {hi, lo};
    endtask

    // ---------------- tests ----------------

    task automatic test_reset_state();
        // all registers zero: a one-pixel outline at the origin, black
        send_pixel(10'd0, 10'd0, 10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023, 10'd1023, 10'd1023);
    endtask

    task automatic test_directed_shapes();
        load_shape(KIND_RECT_OUTLINE, 100, 200, 300, 400, 5, 24'hFFFFFF, 24'h000000);
        send_pixel(100, 200, 0, 0);
        send_pixel(105, 300, 0, 0);
        send_pixel(106, 300, 0, 0);
        send_pixel(295, 300, 0, 0);
        send_pixel(99, 200, 0, 0);

        load_shape(KIND_RECT_FILLED, 100, 200, 300, 400, 5, 24'hFFFFFF, 24'h000000);
        send_pixel(200, 300, 0, 0);
        send_pixel(301, 400, 0, 0);

        load_shape(KIND_HOVER_OUTLINE, 100, 200, 300, 400, 5, 24'h123456, 24'hABCDEF);
        send_pixel(100, 200, 300, 400);
        send_pixel(100, 200, 301, 400);

        // outer bound excluded, inner bound included
        load_shape(KIND_RING, 512, 512, 100, 0, 10, 24'h00FF00, 24'hFF0000);
        send_pixel(612, 512, 0, 0);
        send_pixel(611, 512, 0, 0);
        send_pixel(512, 602, 0, 0);
        send_pixel(512, 601, 0, 0);

        // cursor on the circle is not over it
        load_shape(KIND_HOVER_RING, 512, 512, 100, 1023, 10, 24'h00FF00, 24'hFF0000);
        send_pixel(611, 512, 512, 512);
        send_pixel(611, 512, 612, 512);

        // band thicker than the radius
        load_shape(KIND_RING, 512, 512, 100, 0, 150, 24'h0000FF, 24'h000000);
        send_pixel(552, 512, 0, 0);
        send_pixel(572, 512, 0, 0);

        load_shape(KIND_RECT_FILLED, 500, 300, 400, 600, 0, 24'hFFFFFF, 24'hFFFFFF);
        send_pixel(450, 400, 0, 0);

        load_shape(KIND_UNUSED_TOP, 0, 0, 1023, 1023, 1023, 24'hFFFFFF, 24'hFFFFFF);
        send_pixel(0, 0, 0, 0);

        load_shape(KIND_HOVER_OUTLINE, 0, 0, 1023, 1023, 1023, 24'hFFFFFF, 24'hFFFFFF);
        send_pixel(1023, 1023, 1023, 1023);
        send_pixel(0, 0, 0, 0);
    endtask

    task automatic test_output_stall();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        load_shape(KIND_RECT_FILLED, 0, 0, 511, 511, 0, 24'hA5A5A5, 24'h5A5A5A);
        hold_req = HOLD_CYCLES;
        repeat (40)
            send_pixel(COORD_W'($urandom), COORD_W'($urandom),
                       COORD_W'($urandom), COORD_W'($urandom));
        wait_results_done();
    endtask

    task automatic test_random_traffic(int send_pct, int recv_pct, int n_items);
        logic [KIND_W-1:0]  kind;
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        int  ax, ay, ex, ey, t;
        int  lo_x, hi_x, lo_y, hi_y;
        int  sent;
        int  burst;
        bit  is_ring;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(15) == 0)
                kind = KIND_W'($urandom_range(KIND_UNUSED_TOP, KIND_HOVER_RING + 1));
            else
                kind = KIND_W'($urandom_range(KIND_HOVER_RING, KIND_RECT_OUTLINE));
            is_ring = (kind == KIND_RING || kind == KIND_HOVER_RING);
            rand_span(ax, ex);
            rand_span(ay, ey);
            if (is_ring)
                ex = ($urandom_range(5) == 0) ? $urandom_range(1023) : $urandom_range(150);
            t = ($urandom_range(5) == 0) ? $urandom_range(1023) : $urandom_range(15);
            load_shape(kind, COORD_W'(ax), COORD_W'(ay), COORD_W'(ex), COORD_W'(ey),
                       COORD_W'(t), COLOR_W'($urandom), COLOR_W'($urandom));

            if (is_ring) begin
                lo_x = ax - ex;
                hi_x = ax + ex;
                lo_y = ay - ex;
                hi_y = ay + ex;
            end else begin
                lo_x = ax;
                hi_x = ex;
                lo_y = ay;
                hi_y = ey;
            end
            burst = $urandom_range(60, 20);
            repeat (burst) begin
                px = pick_coord(lo_x, hi_x, t);
                py = pick_coord(lo_y, hi_y, t);
                // points on the axes hit the band boundaries exactly
                if (is_ring) begin
                    case ($urandom_range(3))
                        0: px = COORD_W'(ax);
                        1: py = COORD_W'(ay);
                        default: ;
                    endcase
                end
                if ($urandom_range(6) == 0)
                    {px, py} = (2*COORD_W)'($urandom);
                if ($urandom_range(1) == 0) begin
                    cx = pick_coord(lo_x, hi_x, t);
                    cy = pick_coord(lo_y, hi_y, t);
                end else begin
                    {cx, cy} = (2*COORD_W)'($urandom);
                end
                send_pixel(px, py, cx, cy);
            end
            sent += burst;
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_directed_shapes();
        test_output_stall();
        test_random_traffic(0, 0, 500);
        test_random_traffic(82, 0, 500);
        test_random_traffic(0, 82, 500);
        test_random_traffic(22, 22, 500);
        wait_results_done();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_hits.size() != 0)
            report_mismatch("pixels without result", '0, COLOR_W'(expected_hits.size()));
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
